>>> hdl/cpr_pkg.sv
// shared types, constants and fixed-point helpers for the center of pressure resolver
package cpr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NORM_FRAC     = 30;
    // quotient bits of the cop offset divide, offset clamps to 2^(QBITS-1)
    localparam int QBITS         = 35;
    localparam int TP_W          = 66;
    localparam int ACC_W         = 64;
    localparam int OFF_W         = QBITS + 1;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FORCE = 1'b1;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_LOW_FORCE = 2'd1,
        ST_NOT_UNIT  = 2'd2
    } status_t;

    typedef logic [2:0][31:0] vec_t;

    typedef struct packed
    {
        vec_t t;
        vec_t f;
        vec_t n;
        vec_t p;
    } sample_t;

    typedef struct packed
    {
        logic    valid;
        status_t status;
    } tag_t;

    typedef logic signed [63:0]      prod_t;
    typedef logic signed [TP_W-1:0]  wide_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [OFF_W-1:0] off_t;

    // partial products of a wide value times a q2.30 normal component
    typedef struct packed
    {
        logic signed [64:0]     lo;
        logic signed [TP_W-1:0] hi;
    } mqp_t;

    localparam acc_t S32_MAX = 64'sd2147483647;
    localparam acc_t S32_MIN = -64'sd2147483648;

    function automatic mqp_t mq_split(wide_t a, logic signed [31:0] n);
        mqp_t                   r;
        logic signed [32:0]     al;
        logic signed [TP_W-33:0] ah;
        al   = $signed({1'b0, a[31:0]});
        ah   = a[TP_W-1:32];
        r.lo = al * n;
        r.hi = ah * n;
        return r;
    endfunction

    // floor(a * n / 2^30) from its partial products
    function automatic acc_t mq_join(mqp_t x);
        logic signed [TP_W+31:0] s;
        s = ($signed(x.hi) <<< 32) + $signed(x.lo);
        return s[ACC_W+NORM_FRAC-1:NORM_FRAC];
    endfunction

    // one cross product component floored to the torque format
    function automatic wide_t cross_fix(prod_t pa, prod_t pb, int unsigned frac);
        logic signed [64:0] d;
        logic signed [64:0] s;
        d = pa - pb;
        s = d >>> frac;
        return {s[64], s};
    endfunction

    function automatic logic signed [31:0] sat32(acc_t v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/center_of_pressure_resolver.sv
// top level of the center of pressure resolver: config registers, pipeline and output register
//
//  channel | handshake                      | payload
//  --------+--------------------------------+-------------------------------------------
//  input   | in_valid / in_stall            | torque_*, force_*, normal_*, plane_point_*
//  output  | out_valid / out_stall          | cop_x, cop_y, cop_z, normal_torque, status
//  config  | cfg_write, cfg_index, cfg_data | unit_tolerance (0), min_normal_force (1)
//
//  one item per cycle unless the pipeline holds; the divider resolves one quotient bit
//  per stage; all stages move on one enable; the pipeline holds whenever a result
//  sits in the output register and out_stall is high, and in_stall is raised in that
//  cycle; reset clears the valid bits and loads both config registers with 1
//  config writes take effect at once; the user must make them only while the pipeline
//  is empty, and the block itself does not enforce this
module center_of_pressure_resolver
    import cpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [31:0]    torque_x,
    input  logic signed [31:0]    torque_y,
    input  logic signed [31:0]    torque_z,
    input  logic signed [31:0]    force_x,
    input  logic signed [31:0]    force_y,
    input  logic signed [31:0]    force_z,
    input  logic signed [31:0]    normal_x,
    input  logic signed [31:0]    normal_y,
    input  logic signed [31:0]    normal_z,
    input  logic signed [31:0]    plane_point_x,
    input  logic signed [31:0]    plane_point_y,
    input  logic signed [31:0]    plane_point_z,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    cop_x,
    output logic signed [31:0]    cop_y,
    output logic signed [31:0]    cop_z,
    output logic signed [31:0]    normal_torque,
    output logic [1:0]            status
);

    // config registers
    logic [29:0] unit_tol_reg;
    logic [30:0] min_force_reg;

    // pipeline enable: stop only when a held result is not taken
    logic en;

    sample_t in_smp;

    tag_t    fr_tag;
    sample_t fr_smp;
    acc_t    fr_m [3];
    acc_t    fr_fz;

    tag_t    dv_tag;
    sample_t dv_smp;
    off_t    dv_off [3];

    tag_t               bk_tag;
    logic signed [31:0] bk_cop [3];
    acc_t               bk_nq [3];

    // output register
    logic               out_valid_reg;
    logic signed [31:0] cop_x_reg;
    logic signed [31:0] cop_y_reg;
    logic signed [31:0] cop_z_reg;
    logic signed [31:0] nt_reg;
    status_t            status_reg;

    logic               ok;
    logic signed [31:0] nt_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_tol_reg  <= 30'd1;
            min_force_reg <= 31'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_UNIT_TOL:  unit_tol_reg  <= cfg_data[29:0];
                CFG_MIN_FORCE: min_force_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // pack the sample, index 0 is x
    assign in_smp.t = {torque_z, torque_y, torque_x};
    assign in_smp.f = {force_z, force_y, force_x};
    assign in_smp.n = {normal_z, normal_y, normal_x};
    assign in_smp.p = {plane_point_z, plane_point_y, plane_point_x};

    // moved torque, checks, normal force, numerator n x tp
    cpr_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_smp    (in_smp),
        .unit_tol  (unit_tol_reg),
        .min_force (min_force_reg),
        .out_tag   (fr_tag),
        .out_smp   (fr_smp),
        .out_m     (fr_m),
        .out_fz    (fr_fz)
    );

    // offset = numerator * 2^(frac + 28) / fz, clamped
    cpr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (fr_tag),
        .in_smp  (fr_smp),
        .in_m    (fr_m),
        .in_fz   (fr_fz),
        .out_tag (dv_tag),
        .out_smp (dv_smp),
        .out_off (dv_off)
    );

    // cop and per-axis parts of the normal torque
    cpr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (dv_tag),
        .in_smp  (dv_smp),
        .in_off  (dv_off),
        .out_tag (bk_tag),
        .out_cop (bk_cop),
        .out_nq  (bk_nq)
    );

    assign ok     = (bk_tag.status == ST_OK);
    assign nt_sat = sat32(bk_nq[0] + bk_nq[1] + bk_nq[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= bk_tag.valid;
        end
    end

    // faults give zeroed results
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cop_x_reg  <= ok ? bk_cop[0] : 32'sd0;
            cop_y_reg  <= ok ? bk_cop[1] : 32'sd0;
            cop_z_reg  <= ok ? bk_cop[2] : 32'sd0;
            nt_reg     <= ok ? nt_sat : 32'sd0;
            status_reg <= bk_tag.status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cop_x         = cop_x_reg;
    assign cop_y         = cop_y_reg;
    assign cop_z         = cop_z_reg;
    assign normal_torque = nt_reg;
    assign status        = status_reg;

`ifndef ASSERT_OFF
    // a held result freezes the whole pipeline, input included
    a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while result held");

    // any fault status carries zeroed results
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
        (cop_x == 32'sd0 && cop_y == 32'sd0 && cop_z == 32'sd0 && normal_torque == 32'sd0))
        else $error("fault item with nonzero results");

    // free output side means the input is never stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled with free output");
`endif

endmodule

>>> hdl/cpr_front.sv
// front stages: moved torque, normal checks, normal force and cop numerator
module cpr_front
    import cpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  sample_t     in_smp,
    input  logic [29:0] unit_tol,
    input  logic [30:0] min_force,
    output tag_t        out_tag,
    output sample_t     out_smp,
    output acc_t        out_m [3],
    output acc_t        out_fz
);

    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

    // stage 1: products
    logic    v1_reg;
    sample_t s1_reg;
    prod_t   pa1_reg [3];
    prod_t   pb1_reg [3];
    prod_t   nn1_reg [3];
    prod_t   nf1_reg [3];

    // stage 2: moved torque, squared length, normal force
    logic        v2_reg;
    sample_t     s2_reg;
    wide_t       tp2_reg [3];
    logic [63:0] sq2_reg;
    acc_t        fz2_reg;

    // stage 3: status and partial products of n x tp
    tag_t    t3_reg;
    sample_t s3_reg;
    acc_t    fz3_reg;
    mqp_t    mqa3_reg [3];
    mqp_t    mqb3_reg [3];

    // stage 4: numerator
    tag_t    t4_reg;
    sample_t s4_reg;
    acc_t    fz4_reg;
    acc_t    m4_reg [3];

    logic [63:0] dev;
    logic [63:0] fz_mag;
    status_t     st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            t3_reg <= '{valid: v2_reg, status: st_next};
            t4_reg <= t3_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        localparam int A = (i + 1) % 3;
        localparam int B = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa1_reg[i]  <= $signed(in_smp.p[A]) * $signed(in_smp.f[B]);
                pb1_reg[i]  <= $signed(in_smp.p[B]) * $signed(in_smp.f[A]);
                nn1_reg[i]  <= $signed(in_smp.n[i]) * $signed(in_smp.n[i]);
                nf1_reg[i]  <= $signed(in_smp.n[i]) * $signed(in_smp.f[i]);
                tp2_reg[i]  <= $signed(s1_reg.t[i]) - cross_fix(pa1_reg[i], pb1_reg[i], FRAC_BITS);
                mqa3_reg[i] <= mq_split(tp2_reg[B], $signed(s2_reg.n[A]));
                mqb3_reg[i] <= mq_split(tp2_reg[A], $signed(s2_reg.n[B]));
                m4_reg[i]   <= mq_join(mqa3_reg[i]) - mq_join(mqb3_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= in_smp;
            s2_reg  <= s1_reg;
            s3_reg  <= s2_reg;
            s4_reg  <= s3_reg;
            sq2_reg <= 64'(nn1_reg[0]) + 64'(nn1_reg[1]) + 64'(nn1_reg[2]);
            fz2_reg <= (nf1_reg[0] >>> 2) + (nf1_reg[1] >>> 2) + (nf1_reg[2] >>> 2);
            fz3_reg <= fz2_reg;
            fz4_reg <= fz3_reg;
        end
    end

    // unit check first, then the normal force
    always_comb
    begin
        dev    = (sq2_reg >= ONE_Q60) ? (sq2_reg - ONE_Q60) : (ONE_Q60 - sq2_reg);
        fz_mag = fz2_reg[63] ? (~fz2_reg + 64'd1) : fz2_reg;
        if (dev > {4'b0, unit_tol, 30'b0})
        begin
            st_next = ST_NOT_UNIT;
        end
        else if (!(fz_mag > {5'b0, min_force, 28'b0}))
        begin
            st_next = ST_LOW_FORCE;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    assign out_tag = t4_reg;
    assign out_smp = s4_reg;
    assign out_m   = m4_reg;
    assign out_fz  = fz4_reg;

endmodule

>>> hdl/cpr_div.sv
// pipelined restoring divider for the three cop offsets, one quotient bit a stage
module cpr_div
    import cpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  tag_t    in_tag,
    input  sample_t in_smp,
    input  acc_t    in_m [3],
    input  acc_t    in_fz,
    output tag_t    out_tag,
    output sample_t out_smp,
    output off_t    out_off [3]
);

    localparam int SH   = FRAC_BITS + 28 - QBITS;
    localparam int R0_W = ACC_W + SH;
    localparam logic [QBITS-1:0] CAP = {1'b1, {(QBITS-1){1'b0}}};

    tag_t             tag_reg [QBITS+2];
    sample_t          smp_reg [QBITS+2];
    logic [62:0]      dm_reg  [QBITS+1];
    logic [63:0]      r_reg   [QBITS+1][3];
    logic [QBITS-1:0] q_reg   [QBITS+1][3];
    logic             ovf_reg [QBITS+1][3];
    logic             neg_reg [QBITS+1][3];
    off_t             off_reg [3];

    logic [63:0] fz_abs;

    assign fz_abs = in_fz[63] ? (~in_fz + 64'd1) : in_fz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp_reg[0] <= in_smp;
            dm_reg[0]  <= fz_abs[62:0];
        end
    end

    // setup: integer part beyond the quotient range means clamp
    for (genvar i = 0; i < 3; i++)
    begin : g_setup
        logic [63:0]     nm;
        logic [R0_W-1:0] r0;
        logic            ovf;

        assign nm  = in_m[i][63] ? (~in_m[i] + 64'd1) : in_m[i];
        assign r0  = {nm, {SH{1'b0}}};
        assign ovf = r0 >= {{(R0_W-63){1'b0}}, fz_abs[62:0]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[0][i]   <= ovf ? 64'd0 : r0[63:0];
                q_reg[0][i]   <= '0;
                ovf_reg[0][i] <= ovf;
                neg_reg[0][i] <= in_m[i][63] ^ in_fz[63];
            end
        end
    end

    for (genvar k = 1; k <= QBITS; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                smp_reg[k] <= smp_reg[k-1];
                dm_reg[k]  <= dm_reg[k-1];
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [63:0] rs;
            logic        ge;

            assign rs = {r_reg[k-1][i][62:0], 1'b0};
            assign ge = rs >= {1'b0, dm_reg[k-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k][i]   <= ge ? (rs - {1'b0, dm_reg[k-1]}) : rs;
                    q_reg[k][i]   <= {q_reg[k-1][i][QBITS-2:0], ge};
                    ovf_reg[k][i] <= ovf_reg[k-1][i];
                    neg_reg[k][i] <= neg_reg[k-1][i];
                end
            end
        end
    end

    // clamp and sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[QBITS+1] <= '0;
        end
        else if (en)
        begin
            tag_reg[QBITS+1] <= tag_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp_reg[QBITS+1] <= smp_reg[QBITS];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_fin
        logic [QBITS-1:0] qc;

        assign qc = (ovf_reg[QBITS][i] || (q_reg[QBITS][i] > CAP)) ? CAP : q_reg[QBITS][i];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                off_reg[i] <= neg_reg[QBITS][i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
            end
        end
    end

    assign out_tag = tag_reg[QBITS+1];
    assign out_smp = smp_reg[QBITS+1];
    assign out_off = off_reg;

endmodule

>>> hdl/cpr_back.sv
// back stages: saturated cop and the torque about the normal at the cop
module cpr_back
    import cpr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  tag_t               in_tag,
    input  sample_t            in_smp,
    input  off_t               in_off [3],
    output tag_t               out_tag,
    output logic signed [31:0] out_cop [3],
    output acc_t               out_nq [3]
);

    tag_t               t1_reg;
    tag_t               t2_reg;
    tag_t               t3_reg;
    tag_t               t4_reg;
    tag_t               t5_reg;
    sample_t            s1_reg;
    sample_t            s2_reg;
    sample_t            s3_reg;
    logic signed [31:0] c1_reg [3];
    logic signed [31:0] c2_reg [3];
    logic signed [31:0] c3_reg [3];
    logic signed [31:0] c4_reg [3];
    logic signed [31:0] c5_reg [3];
    prod_t              pa2_reg [3];
    prod_t              pb2_reg [3];
    wide_t              tc3_reg [3];
    mqp_t               mq4_reg [3];
    acc_t               nq5_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else if (en)
        begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= in_smp;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        localparam int A = (i + 1) % 3;
        localparam int B = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c1_reg[i]  <= sat32(acc_t'($signed(in_smp.p[i])) + acc_t'(in_off[i]));
                c2_reg[i]  <= c1_reg[i];
                c3_reg[i]  <= c2_reg[i];
                c4_reg[i]  <= c3_reg[i];
                c5_reg[i]  <= c4_reg[i];
                pa2_reg[i] <= c1_reg[A] * $signed(s1_reg.f[B]);
                pb2_reg[i] <= c1_reg[B] * $signed(s1_reg.f[A]);
                tc3_reg[i] <= $signed(s2_reg.t[i]) - cross_fix(pa2_reg[i], pb2_reg[i], FRAC_BITS);
                mq4_reg[i] <= mq_split(tc3_reg[i], $signed(s3_reg.n[i]));
                nq5_reg[i] <= mq_join(mq4_reg[i]);
            end
        end
    end

    assign out_tag = t5_reg;
    assign out_cop = c5_reg;
    assign out_nq  = nq5_reg;

endmodule
